// ===== rtl/isc_pkg.sv =====
// Shared types, widths and constants for the impedance sweep calculator.
// Used by isc_div, isc_cordic and impedance_sweep_calculator_core.
`timescale 1ns / 1ps

package isc_pkg;

   // sweep and CORDIC sizing
   localparam int SWEEP_POINTS = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int COUNT_CAP    = 31;

   // datapath widths
   localparam int XY_W   = 36;   // CORDIC x/y, carries Z * 256 with gain
   localparam int ANG_W  = 26;   // CORDIC angle, 2^-24 turn units
   localparam int DVD_W  = 41;   // divider dividend / quotient
   localparam int DVS_W  = 16;   // divider divisor
   localparam int STEP_W = 5;    // CORDIC step counter, table of 23 angles

   // 1 / CORDIC gain in Q30
   localparam logic [30:0] INV_GAIN_Q30 = 31'd652032874;

   // register indexes of the configuration port
   localparam logic CSR_CAL_IMPEDANCE = 1'b0;
   localparam logic CSR_RESULT_OFFSET = 1'b1;

   // request kinds
   localparam logic REQ_CALIBRATE = 1'b0;
   localparam logic REQ_MEASURE   = 1'b1;

   // command to the CORDIC unit
   typedef struct packed {
      logic start;
      logic vec;    // 1: vectoring (phase), 0: rotation
   } cordic_cmd_type;

   // atan(2^-i) in 2^-24 turn
   function automatic logic [21:0] atan_angle(input logic [STEP_W-1:0] i);
      logic [21:0] v;
      case (i)
         5'd0:    v = 22'd2097152;
         5'd1:    v = 22'd1238021;
         5'd2:    v = 22'd654136;
         5'd3:    v = 22'd332050;
         5'd4:    v = 22'd166669;
         5'd5:    v = 22'd83416;
         5'd6:    v = 22'd41718;
         5'd7:    v = 22'd20860;
         5'd8:    v = 22'd10430;
         5'd9:    v = 22'd5215;
         5'd10:   v = 22'd2608;
         5'd11:   v = 22'd1304;
         5'd12:   v = 22'd652;
         5'd13:   v = 22'd326;
         5'd14:   v = 22'd163;
         5'd15:   v = 22'd81;
         5'd16:   v = 22'd41;
         5'd17:   v = 22'd20;
         5'd18:   v = 22'd10;
         5'd19:   v = 22'd5;
         5'd20:   v = 22'd3;
         5'd21:   v = 22'd1;
         5'd22:   v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/isc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on isc_pkg for widths.
`timescale 1ns / 1ps

module isc_div
   import isc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DVD_W-1:0] quotient,
   output logic             done
);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   shifted;
   logic             ge;

   // one shift / compare / subtract step
   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = 6'(DVD_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DVS_W'(shifted - {1'b0, dvs_ff}) : shifted[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== rtl/isc_cordic.sv =====
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on isc_pkg for widths and the arctangent table.
`timescale 1ns / 1ps

module isc_cordic
   import isc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cordic_cmd_type          cmd,
   input  logic signed [XY_W-1:0]  x0,
   input  logic signed [XY_W-1:0]  y0,
   input  logic signed [ANG_W-1:0] z0,
   output logic signed [XY_W-1:0]  x_out,
   output logic signed [XY_W-1:0]  y_out,
   output logic signed [ANG_W-1:0] z_out,
   output logic                    done
);

   logic signed [XY_W-1:0]  x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [ANG_W-1:0] z_ff, z_in, ang;
   logic [STEP_W-1:0]       i_ff, i_in;
   logic                    vec_ff, vec_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic                    up;

   always_comb begin
      dx  = x_ff >>> i_ff;
      dy  = y_ff >>> i_ff;
      ang = ANG_W'(atan_angle(i_ff));
      // vectoring drives y to zero, rotation drives the angle to zero
      up  = vec_ff ? (y_ff > 0) : z_ff[ANG_W-1];
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      vec_in  = vec_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         x_in    = x0;
         y_in    = y0;
         z_in    = z0;
         i_in    = '0;
         vec_in  = cmd.vec;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (up) begin
            x_in = x_ff + dy;
            y_in = y_ff - dx;
            z_in = z_ff + ang;
         end else begin
            x_in = x_ff - dy;
            y_in = y_ff + dx;
            z_in = z_ff - ang;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      i_ff   <= i_in;
      vec_ff <= vec_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
   assign done  = done_ff;

endmodule

// ===== rtl/impedance_sweep_calculator_core.sv =====
// Impedance sweep calculator: magnitude, phase, gain-factor impedance, averages.
// A measure word runs on past a calibrate word (division, rotation, gain removal);
// a last point adds three averaging divisions and the result output state.
// Throughput: one word at a time; set by the 16-step square root, the shared
// CORDIC (16 steps) and the bit-serial divider (41 steps).
// Reset (synchronous, active high) clears sums, flags and table; cal 462, offset 102.
`timescale 1ns / 1ps

module impedance_sweep_calculator_core
   import isc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // point_index[3:0], real_part[19:4], imag_part[35:20]
   input  logic        req_tuser,   // req_type
   input  logic        req_tlast,   // last_point
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // total_impedance[23:0], active_part[47:24],
                                    // reactive_part[71:48], zero_magnitude[72], saturated[73]
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   typedef enum logic [21:0] {
      ST_IDLE     = 22'h000001,
      ST_SQ_RE    = 22'h000002,
      ST_SQ_IM    = 22'h000004,
      ST_SQ_SUM   = 22'h000008,
      ST_SQRT     = 22'h000010,
      ST_VEC_GO   = 22'h000020,
      ST_VEC_WAIT = 22'h000040,
      ST_DISPATCH = 22'h000080,
      ST_MUL_CZ   = 22'h000100,
      ST_DIV_Z    = 22'h000200,
      ST_DIV_WAIT = 22'h000400,
      ST_ROT_GO   = 22'h000800,
      ST_ROT_WAIT = 22'h001000,
      ST_GX_LO    = 22'h002000,
      ST_GX_HI    = 22'h004000,
      ST_GY_LO    = 22'h008000,
      ST_GY_HI    = 22'h010000,
      ST_G_END    = 22'h020000,
      ST_ACCUM    = 22'h040000,
      ST_AVG_GO   = 22'h080000,
      ST_AVG_WAIT = 22'h100000,
      ST_OUT      = 22'h200000
   } state_type;

   localparam logic signed [67:0] OUT_MAX_V = 68'sd8388607;
   localparam logic signed [67:0] OUT_MIN_V = -68'sd8388608;

   // clip to 24 bits, top bit of the result flags a clip
   function automatic logic [24:0] clip24(input logic signed [67:0] v);
      logic [24:0] r;
      if (v > OUT_MAX_V) begin
         r = {1'b1, 24'h7fffff};
      end else if (v < OUT_MIN_V) begin
         r = {1'b1, 24'h800000};
      end else begin
         r = {1'b0, v[23:0]};
      end
      return r;
   endfunction

   // round an accumulated Q38 product to Q0 and clip
   function automatic logic [24:0] gain_round(input logic signed [67:0] v);
      logic signed [67:0] t;
      t = (v + (68'sd1 <<< 37)) >>> 38;
      return clip24(t);
   endfunction

   state_type state_ff, state_in;

   logic              kind_ff, kind_in, last_ff, last_in;
   logic [3:0]        idx_ff, idx_in;
   logic signed [15:0] re_ff, re_in, im_ff, im_in;
   logic [15:0]       cal_ff, cal_in, off_ff, off_in;
   logic [15:0]       ref_mag_ff [16];
   logic [15:0]       ref_ph_ff  [16];
   logic              ref_we;
   logic signed [49:0] prod_ff, prod_in;
   logic [31:0]       n_ff, n_in, sq_rem_ff, sq_rem_in, sq_r_ff, sq_r_in;
   logic [3:0]        sq_cnt_ff, sq_cnt_in;
   logic [15:0]       mag_ff, mag_in, ph_ff, ph_in;
   logic [23:0]       z_ff, z_in;
   logic signed [23:0] c_ff, c_in, s_ff, s_in;
   logic signed [67:0] acc_ff, acc_in;
   logic signed [31:0] sum_t_ff, sum_t_in, sum_a_ff, sum_a_in, sum_r_ff, sum_r_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [1:0]        flags_ff, flags_in;
   logic [1:0]        sel_ff, sel_in;
   logic              neg_ff, neg_in;
   logic [23:0]       avg_ff [3];
   logic [23:0]       avg_in [3];
   logic              rsp_valid_ff, rsp_valid_in;
   logic [73:0]       rsp_data_ff, rsp_data_in;

   // shared multiplier operands
   logic signed [18:0] mul_a;
   logic signed [30:0] mul_b;

   // sub-unit wiring
   cordic_cmd_type          cor_cmd;
   logic signed [XY_W-1:0]  cor_x0, cor_y0, cor_x, cor_y;
   logic signed [ANG_W-1:0] cor_z0, cor_z;
   logic                    cor_done;
   logic                    div_start, div_done;
   logic [DVD_W-1:0]        div_dvd, div_quo;
   logic [DVS_W-1:0]        div_dvs;

   // scratch
   logic [31:0]        bit_v, trial;
   logic               in_sweep, can_sum, out_free;
   logic [15:0]        rm, d_ang;
   logic [23:0]        ph_sum;
   logic [24:0]        clip_v;
   logic signed [31:0] sum_sel;
   logic [32:0]        mag_s;
   logic signed [67:0] avg_v;
   logic [DVD_W-1:0]   quo_v;

   isc_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (cor_cmd),
      .x0    (cor_x0),
      .y0    (cor_y0),
      .z0    (cor_z0),
      .x_out (cor_x),
      .y_out (cor_y),
      .z_out (cor_z),
      .done  (cor_done)
   );

   isc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quotient (div_quo),
      .done     (div_done)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff};

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQ_RE: begin
            mul_a = 19'(re_ff);
            mul_b = 31'(re_ff);
         end
         ST_SQ_IM: begin
            mul_a = 19'(im_ff);
            mul_b = 31'(im_ff);
         end
         ST_MUL_CZ: begin
            mul_a = {3'b0, cal_ff};
            mul_b = {15'b0, ref_mag_ff[idx_ff]};
         end
         ST_GX_LO: begin
            mul_a = {1'b0, cor_x[17:0]};
            mul_b = INV_GAIN_Q30;
         end
         ST_GX_HI: begin
            mul_a = 19'($signed(cor_x[35:18]));
            mul_b = INV_GAIN_Q30;
         end
         ST_GY_LO: begin
            mul_a = {1'b0, cor_y[17:0]};
            mul_b = INV_GAIN_Q30;
         end
         ST_GY_HI: begin
            mul_a = 19'($signed(cor_y[35:18]));
            mul_b = INV_GAIN_Q30;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      re_in        = re_ff;
      im_in        = im_ff;
      cal_in       = cal_ff;
      off_in       = off_ff;
      ref_we       = 1'b0;
      prod_in      = mul_a * mul_b;
      n_in         = n_ff;
      sq_rem_in    = sq_rem_ff;
      sq_r_in      = sq_r_ff;
      sq_cnt_in    = sq_cnt_ff;
      mag_in       = mag_ff;
      ph_in        = ph_ff;
      z_in         = z_ff;
      c_in         = c_ff;
      s_in         = s_ff;
      acc_in       = acc_ff;
      sum_t_in     = sum_t_ff;
      sum_a_in     = sum_a_ff;
      sum_r_in     = sum_r_ff;
      cnt_in       = cnt_ff;
      flags_in     = flags_ff;
      sel_in       = sel_ff;
      neg_in       = neg_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cor_cmd      = '0;
      cor_x0       = '0;
      cor_y0       = '0;
      cor_z0       = '0;
      div_start    = 1'b0;
      div_dvd      = '0;
      div_dvs      = '0;

      bit_v    = 32'd1 << {sq_cnt_ff, 1'b0};
      trial    = sq_r_ff + bit_v;
      in_sweep = 32'(idx_ff) < SWEEP_POINTS;
      can_sum  = in_sweep && (32'(cnt_ff) < COUNT_CAP) && (32'(cnt_ff) < SWEEP_POINTS);
      rm       = ref_mag_ff[idx_ff];
      d_ang    = ph_ff - ref_ph_ff[idx_ff];
      ph_sum   = cor_z[23:0] + 24'h80;
      out_free = !rsp_valid_ff || rsp_tready;
      clip_v   = '0;
      avg_v    = '0;
      quo_v    = '0;
      mag_s    = '0;

      case (sel_ff)
         2'd0:    sum_sel = sum_t_ff;
         2'd1:    sum_sel = sum_a_ff;
         default: sum_sel = sum_r_ff;
      endcase

      // result word leaves
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // configuration write
      if (csr_valid) begin
         case (csr_index)
            CSR_CAL_IMPEDANCE: cal_in = csr_data;
            CSR_RESULT_OFFSET: off_in = csr_data;
            default:           cal_in = cal_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               last_in  = req_tlast;
               idx_in   = req_tdata[3:0];
               re_in    = req_tdata[19:4];
               im_in    = req_tdata[35:20];
               state_in = ST_SQ_RE;
            end
         end
         ST_SQ_RE: state_in = ST_SQ_IM;
         ST_SQ_IM: begin
            n_in     = prod_ff[31:0];
            state_in = ST_SQ_SUM;
         end
         ST_SQ_SUM: begin
            sq_rem_in = n_ff + prod_ff[31:0];
            sq_r_in   = '0;
            sq_cnt_in = 4'd15;
            state_in  = ST_SQRT;
         end
         // one root bit per cycle
         ST_SQRT: begin
            if (sq_rem_ff >= trial) begin
               sq_rem_in = sq_rem_ff - trial;
               sq_r_in   = (sq_r_ff >> 1) + bit_v;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
            sq_cnt_in = sq_cnt_ff - 4'd1;
            if (sq_cnt_ff == '0) begin
               state_in = ST_VEC_GO;
            end
         end
         ST_VEC_GO: begin
            mag_in      = 16'(sq_r_ff + 32'(sq_rem_ff > sq_r_ff));
            cor_cmd.start = 1'b1;
            cor_cmd.vec   = 1'b1;
            if (re_ff[15]) begin
               cor_x0 = -(XY_W'(re_ff) <<< 8);
               cor_y0 = -(XY_W'(im_ff) <<< 8);
               cor_z0 = ANG_W'(24'h800000);
            end else begin
               cor_x0 = XY_W'(re_ff) <<< 8;
               cor_y0 = XY_W'(im_ff) <<< 8;
               cor_z0 = '0;
            end
            state_in = ST_VEC_WAIT;
         end
         ST_VEC_WAIT: begin
            if (cor_done) begin
               ph_in    = (re_ff == '0 && im_ff == '0) ? 16'd0 : ph_sum[23:8];
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (kind_ff == REQ_CALIBRATE) begin
               ref_we   = in_sweep;
               state_in = ST_IDLE;
            end else if (can_sum) begin
               if (mag_ff == '0 || rm == '0) begin
                  flags_in[0] = 1'b1;
                  z_in        = '0;
                  c_in        = '0;
                  s_in        = '0;
                  state_in    = ST_ACCUM;
               end else begin
                  state_in = ST_MUL_CZ;
               end
            end else begin
               sel_in   = '0;
               state_in = last_ff ? ST_AVG_GO : ST_IDLE;
            end
         end
         ST_MUL_CZ: state_in = ST_DIV_Z;
         // Z = cal * ref_mag * 256 / mag, rounded
         ST_DIV_Z: begin
            div_start = 1'b1;
            div_dvd   = {1'b0, prod_ff[31:0], 8'b0} + DVD_W'(mag_ff >> 1);
            div_dvs   = mag_ff;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               if (div_quo > DVD_W'(24'h7fffff)) begin
                  z_in        = 24'h7fffff;
                  flags_in[1] = 1'b1;
               end else begin
                  z_in = div_quo[23:0];
               end
               state_in = ST_ROT_GO;
            end
         end
         // rotate (Z, 0) by the phase difference, folded into +-90 degrees
         ST_ROT_GO: begin
            cor_cmd.start = 1'b1;
            cor_cmd.vec   = 1'b0;
            cor_y0        = '0;
            if (d_ang >= 16'h4000 && d_ang < 16'hC000) begin
               cor_x0 = -(XY_W'({z_ff, 8'b0}));
               cor_z0 = ANG_W'($signed(d_ang - 16'h8000)) <<< 8;
            end else begin
               cor_x0 = XY_W'({z_ff, 8'b0});
               cor_z0 = ANG_W'($signed(d_ang)) <<< 8;
            end
            state_in = ST_ROT_WAIT;
         end
         ST_ROT_WAIT: begin
            if (cor_done) begin
               state_in = ST_GX_LO;
            end
         end
         // gain removal, each 36-bit value as two 18-bit partial products
         ST_GX_LO: state_in = ST_GX_HI;
         ST_GX_HI: begin
            acc_in   = 68'(prod_ff);
            state_in = ST_GY_LO;
         end
         ST_GY_LO: begin
            clip_v      = gain_round(acc_ff + (68'(prod_ff) <<< 18));
            c_in        = clip_v[23:0];
            flags_in[1] = flags_ff[1] | clip_v[24];
            state_in    = ST_GY_HI;
         end
         ST_GY_HI: begin
            acc_in   = 68'(prod_ff);
            state_in = ST_G_END;
         end
         ST_G_END: begin
            clip_v      = gain_round(acc_ff + (68'(prod_ff) <<< 18));
            s_in        = clip_v[23:0];
            flags_in[1] = flags_ff[1] | clip_v[24];
            state_in    = ST_ACCUM;
         end
         ST_ACCUM: begin
            sum_t_in = sum_t_ff + $signed({8'b0, z_ff});
            sum_a_in = sum_a_ff + 32'(c_ff);
            sum_r_in = sum_r_ff + 32'(s_ff);
            cnt_in   = cnt_ff + 5'd1;
            sel_in   = '0;
            state_in = last_ff ? ST_AVG_GO : ST_IDLE;
         end
         // average: (|sum| + n/2) / n, sign restored, offset * 256 taken off total and active
         ST_AVG_GO: begin
            neg_in    = sum_sel[31];
            mag_s     = sum_sel[31] ? 33'(-(33'(sum_sel))) : 33'(sum_sel);
            div_start = 1'b1;
            div_dvd   = DVD_W'(mag_s) + DVD_W'(cnt_ff >> 1);
            div_dvs   = DVS_W'(cnt_ff);
            state_in  = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (div_done) begin
               quo_v = (cnt_ff == '0) ? '0 : div_quo;
               avg_v = neg_ff ? -(68'(quo_v)) : 68'(quo_v);
               if (sel_ff != 2'd2) begin
                  avg_v = avg_v - 68'({off_ff, 8'b0});
               end
               clip_v         = clip24(avg_v);
               avg_in[sel_ff] = clip_v[23:0];
               flags_in[1]    = flags_ff[1] | clip_v[24];
               if (sel_ff == 2'd2) begin
                  state_in = ST_OUT;
               end else begin
                  sel_in   = sel_ff + 2'd1;
                  state_in = ST_AVG_GO;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {flags_ff[1], flags_ff[0], avg_ff[2], avg_ff[1], avg_ff[0]};
               sum_t_in     = '0;
               sum_a_in     = '0;
               sum_r_in     = '0;
               cnt_in       = '0;
               flags_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      re_ff       <= re_in;
      im_ff       <= im_in;
      prod_ff     <= prod_in;
      n_ff        <= n_in;
      sq_rem_ff   <= sq_rem_in;
      sq_r_ff     <= sq_r_in;
      sq_cnt_ff   <= sq_cnt_in;
      mag_ff      <= mag_in;
      ph_ff       <= ph_in;
      z_ff        <= z_in;
      c_ff        <= c_in;
      s_ff        <= s_in;
      acc_ff      <= acc_in;
      sel_ff      <= sel_in;
      neg_ff      <= neg_in;
      avg_ff      <= avg_in;
      rsp_data_ff <= rsp_data_in;
   end

   // control state, sums and calibration table
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cal_ff       <= 16'd462;
         off_ff       <= 16'd102;
         sum_t_ff     <= '0;
         sum_a_ff     <= '0;
         sum_r_ff     <= '0;
         cnt_ff       <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 16; k++) begin
            ref_mag_ff[k] <= '0;
            ref_ph_ff[k]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cal_ff       <= cal_in;
         off_ff       <= off_in;
         sum_t_ff     <= sum_t_in;
         sum_a_ff     <= sum_a_in;
         sum_r_ff     <= sum_r_in;
         cnt_ff       <= cnt_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ref_we) begin
            ref_mag_ff[idx_ff] <= mag_ff;
            ref_ph_ff[idx_ff]  <= ph_ff;
         end
      end
   end

`ifndef SYNTH
   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= SWEEP_POINTS)
      else $error("point count beyond sweep length");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_SQ_RE))
      else $error("accepted word did not start the sequence");

   a_sweep_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && (!rsp_tvalid || rsp_tready)) |=>
         (cnt_ff == '0 && flags_ff == '0 && rsp_tvalid))
      else $error("sweep state not cleared on result");
`endif

endmodule
